// File: src/cross_morphology_filter_top_macros.svh
// Assertion macros for the cross morphology filter checker.
// Depends on nothing; taken in by the checker with an include.
`ifndef CROSS_MORPHOLOGY_FILTER_TOP_MACROS_SVH
`define CROSS_MORPHOLOGY_FILTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CMF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("cross morphology filter: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CMF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("cross morphology filter: next-cycle check failed");

`endif

// File: src/cmf_pkg.sv
// Shared types and constants of the cross morphology filter.
// No dependencies; used by every module of the block but cmf_line_buf.
`timescale 1ns / 1ps
`default_nettype none

package cmf_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int MAX_HEIGHT = 4096;

	localparam int PIX_W = 8;
	localparam int WIDTH_W = 11;
	localparam int HEIGHT_W = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MODE = 2'd2;

	localparam logic [PIX_W-1:0] TARGET_DILATE = 8'h00;
	localparam logic [PIX_W-1:0] TARGET_ERODE = 8'hFF;

	// Where the current result pixel sits with respect to the image border.
	typedef struct packed {
		logic vld;
		logic up_ok;
		logic down_ok;
		logic left_ok;
		logic right_ok;
		logic last;
	} pos_t;

endpackage

`default_nettype wire

// File: src/cross_morphology_filter_top.sv
// Cross-shaped 3x3 morphology filter, one pixel per clock in and out unless stalled.
// A result passes pos_s1 and the output register after the transfer of the pixel
// one row and one column behind it; frames drain with width+1 flush transfers.
// Throughput: one transfer per cycle unless stalled, bounded by one-port line RAMs.
// Reset restores the default configuration and clears the position counters and the
// handshake state; the window registers and line RAMs are not cleared.
// Depends on cmf_pkg, cmf_line_buf, cmf_ctrl and cmf_result.
`timescale 1ns / 1ps
`default_nettype none

module cross_morphology_filter_top #(
	parameter int MAX_WIDTH = cmf_pkg::MAX_WIDTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output      logic                            s_tready,
	input  wire logic [7:0]                      s_tdata,   // [7:0] pixel_in
	input  wire logic [0:0]                      s_tuser,   // [0] flush_tick
	output      logic                            m_tvalid,
	input  wire logic                            m_tready,
	output      logic [7:0]                      m_tdata,   // [7:0] pixel_out
	output      logic                            m_tlast,
	input  wire logic                            cfg_we,
	input  wire logic [cmf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [cmf_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic                accept;
	logic                out_free;
	logic [CW-1:0]       col;
	cmf_pkg::pos_t       pos_d;
	cmf_pkg::pos_t       pos_s1;
	logic                target_mode;
	logic [7:0]          x;
	logic [7:0]          mid_rd;
	logic [7:0]          up_rd;
	logic [7:0]          win1_q;
	logic [7:0]          win2_q;
	logic [7:0]          prev_x_q;
	logic [7:0]          down_q;

	assign s_tready = !pos_s1.vld || out_free;
	assign accept = s_tvalid && s_tready;
	assign x = s_tuser[0] ? 8'h00 : s_tdata;

	cmf_ctrl #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.col        (col),
		.pos        (pos_d),
		.target_mode(target_mode)
	);

	// The middle line's read port doubles as the right-hand window tap.
	cmf_line_buf #(
		.DEPTH(MAX_WIDTH)
	) u_mid_line (
		.clk  (clk),
		.en   (accept),
		.addr (col),
		.wdata(x),
		.rdata(mid_rd)
	);

	cmf_line_buf #(
		.DEPTH(MAX_WIDTH)
	) u_upper_line (
		.clk  (clk),
		.en   (accept),
		.addr (col),
		.wdata(mid_rd),
		.rdata(up_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_s1 <= '0;
		end else if (accept) begin
			pos_s1 <= pos_d;
		end else if (out_free) begin
			pos_s1.vld <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			win1_q <= mid_rd;
			win2_q <= win1_q;
			down_q <= prev_x_q;
			prev_x_q <= x;
		end
	end

	cmf_result u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.pos_s1     (pos_s1),
		.up         (up_rd),
		.down       (down_q),
		.right_pix  (mid_rd),
		.center_pix (win1_q),
		.left_pix   (win2_q),
		.target_mode(target_mode),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.out_free   (out_free)
	);

endmodule

`default_nettype wire

// File: src/cmf_line_buf.sv
// One line delay: a single-port RAM that returns the old entry while writing the new one.
// Depends on nothing; instantiated twice by the top level.
`timescale 1ns / 1ps
`default_nettype none

module cmf_line_buf #(
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [7:0]               wdata,
	output      logic [7:0]               rdata
);

	logic [7:0] mem [DEPTH];

	// Read-before-write: rdata gets the value stored one row earlier.
	always_ff @(posedge clk) begin
		if (en) begin
			rdata <= mem[addr];
			mem[addr] <= wdata;
		end
	end

endmodule

`default_nettype wire

// File: src/cmf_ctrl.sv
// Configuration registers and stream position counters of the filter.
// Depends on cmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmf_ctrl #(
	parameter int MAX_WIDTH = cmf_pkg::MAX_WIDTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [cmf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [cmf_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            accept,
	output      logic [$clog2(MAX_WIDTH)-1:0]    col,
	output      cmf_pkg::pos_t                   pos,
	output      logic                            target_mode
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int CMPW = (CW > cmf_pkg::WIDTH_W) ? CW : cmf_pkg::WIDTH_W;
	localparam int HW = cmf_pkg::HEIGHT_W;

	logic [cmf_pkg::WIDTH_W-1:0] width_q;
	logic [HW-1:0]               height_q;
	logic                        mode_q;
	logic [CW-1:0]               col_q;
	logic [HW-1:0]               row_q;

	logic [cmf_pkg::WIDTH_W-1:0] w_raw;
	logic [HW-1:0]               h_raw;
	logic                        c_zero;
	logic                        col_end;

	assign w_raw = cfg_data[cmf_pkg::WIDTH_W-1:0];
	assign h_raw = cfg_data[HW-1:0];

	assign c_zero = (col_q == '0);
	assign col_end = (CMPW'(col_q) == CMPW'(width_q - 11'd1));

	// The result pixel lags the input by one row and one column; at column 0
	// it belongs to the last column of the row two rows up.
	always_comb begin
		pos.vld = (row_q >= 13'd2) || ((row_q == 13'd1) && !c_zero);
		pos.up_ok = c_zero ? (row_q >= 13'd3) : (row_q >= 13'd2);
		pos.down_ok = c_zero ? (row_q <= height_q) : (row_q < height_q);
		pos.left_ok = c_zero ? (width_q >= 11'd2) : (CMPW'(col_q) >= CMPW'(2));
		pos.right_ok = !c_zero;
		pos.last = c_zero && ((HW + 1)'(row_q) == (HW + 1)'(height_q) + 14'd1);
	end

	assign col = col_q;
	assign target_mode = mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= cmf_pkg::WIDTH_W'(MAX_WIDTH > 1024 ? 1024 : MAX_WIDTH);
			height_q <= 13'd1024;
			mode_q <= 1'b0;
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cmf_pkg::CFG_IMAGE_WIDTH: begin
					if (w_raw == '0) begin
						width_q <= 11'd1;
					end else if (32'(w_raw) > MAX_WIDTH) begin
						width_q <= cmf_pkg::WIDTH_W'(MAX_WIDTH);
					end else begin
						width_q <= w_raw;
					end
					col_q <= '0;
					row_q <= '0;
				end
				cmf_pkg::CFG_IMAGE_HEIGHT: begin
					if (h_raw == '0) begin
						height_q <= 13'd1;
					end else if (32'(h_raw) > cmf_pkg::MAX_HEIGHT) begin
						height_q <= HW'(cmf_pkg::MAX_HEIGHT);
					end else begin
						height_q <= h_raw;
					end
					col_q <= '0;
					row_q <= '0;
				end
				cmf_pkg::CFG_TARGET_MODE: begin
					mode_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (pos.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_end) begin
				col_q <= '0;
				row_q <= row_q + 13'd1;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: src/cmf_result.sv
// Cross-neighbor compare and the registered output stage of the filter.
// Depends on cmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmf_result (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmf_pkg::pos_t      pos_s1,
	input  wire logic [7:0]         up,
	input  wire logic [7:0]         down,
	input  wire logic [7:0]         right_pix,
	input  wire logic [7:0]         center_pix,
	input  wire logic [7:0]         left_pix,
	input  wire logic               target_mode,
	input  wire logic               m_tready,
	output      logic               m_tvalid,
	output      logic [7:0]         m_tdata,
	output      logic               m_tlast,
	output      logic               out_free
);

	logic       out_vld_q;
	logic [7:0] pix_q;
	logic       last_q;
	logic [7:0] target;
	logic       hit;

	assign target = target_mode ? cmf_pkg::TARGET_ERODE : cmf_pkg::TARGET_DILATE;

	// Neighbors outside the image never count.
	assign hit = (pos_s1.up_ok && (up == target)) ||
		(pos_s1.down_ok && (down == target)) ||
		(pos_s1.left_ok && (left_pix == target)) ||
		(pos_s1.right_ok && (right_pix == target));

	assign out_free = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= pos_s1.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && pos_s1.vld) begin
			pix_q <= hit ? target : center_pix;
			last_q <= pos_s1.last;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = pix_q;
	assign m_tlast = last_q;

endmodule

`default_nettype wire

// File: src/cmf_checker.sv
// Port-level checks of the cross morphology filter, bound to the top level.
// Depends on cross_morphology_filter_top_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "cross_morphology_filter_top_macros.svh"

module cmf_port_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tlast
);

	// A stalled result stays offered.
	`CMF_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	// A stalled result keeps its value.
	`CMF_ASSERT_NXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
	// With room at the output the input side never stalls.
	`CMF_ASSERT_IMP(a_in_ready, clk, arst_n, !m_tvalid || m_tready, s_tready)
	// A fresh result always comes from an earlier input transfer.
	`CMF_ASSERT_IMP(a_out_cause, clk, arst_n, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

endmodule

bind cross_morphology_filter_top cmf_port_checker u_cmf_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);

`default_nettype wire

// File: tb/cmf_checker.sv
`timescale 1ns / 1ps
// Scoreboard of the cross morphology filter: follows register writes and input transfers,
// predicts each filtered pixel and compares it with the output transfers.
// Depends on cmf_pkg.
module cmf_checker
	import cmf_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tready,
	input  wire logic [7:0]             s_tdata,   // [7:0] pixel_in
	input  wire logic [0:0]             s_tuser,   // [0] flush_tick
	input  wire logic                   m_tvalid,
	input  wire logic                   m_tready,
	input  wire logic [7:0]             m_tdata,   // [7:0] pixel_out
	input  wire logic                   m_tlast,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output int unsigned                 mismatch_count,
	output int unsigned                 pending_results
);

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             last;
	} filtered_pixel_t;

	logic [PIX_W-1:0] upper_row [MAX_WIDTH];
	logic [PIX_W-1:0] middle_row [MAX_WIDTH];
	logic [PIX_W-1:0] win_right, win_center, win_left;
	int unsigned in_col, in_row, out_pos;
	int unsigned img_width, img_height;
	logic erode;
	filtered_pixel_t expected_pixels [$];

	task automatic restart_frame();
		in_col = 0;
		in_row = 0;
		out_pos = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin : predict
		int unsigned col, col_prev, q_row;
		logic [PIX_W-1:0] entering, above, below, target;
		logic hit, frame_done;
		filtered_pixel_t produced, oldest;
		if (!arst_n) begin
			for (int i = 0; i < MAX_WIDTH; i++) begin
				upper_row[i] = '0;
				middle_row[i] = '0;
			end
			win_right = '0;
			win_center = '0;
			win_left = '0;
			restart_frame();
			img_width = MAX_WIDTH;
			img_height = 1024;
			erode = 1'b0;
			expected_pixels.delete();
			mismatch_count = 0;
			pending_results <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_IMAGE_WIDTH: begin
						img_width = 32'(cfg_data[WIDTH_W-1:0]);
						if (img_width == 0) img_width = 1;
						if (img_width > MAX_WIDTH) img_width = MAX_WIDTH;
						restart_frame();
					end
					CFG_IMAGE_HEIGHT: begin
						img_height = 32'(cfg_data[HEIGHT_W-1:0]);
						if (img_height == 0) img_height = 1;
						if (img_height > MAX_HEIGHT) img_height = MAX_HEIGHT;
						restart_frame();
					end
					CFG_TARGET_MODE: begin
						erode = cfg_data[0];
					end
					default: begin
					end
				endcase
			end

			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("%0t unexpected output transfer: pixel %0d last %0b",
							$time, m_tdata, m_tlast);
				end else begin
					oldest = expected_pixels.pop_front();
					if (m_tdata !== oldest.pixel || m_tlast !== oldest.last) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display("%0t mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
								$time, oldest.pixel, oldest.last, m_tdata, m_tlast);
					end
				end
			end

			if (s_tvalid && s_tready) begin
				col = (in_col >= img_width) ? 0 : in_col;
				col_prev = (col != 0) ? col - 1 : img_width - 1;
				entering = s_tuser[0] ? 8'd0 : s_tdata;

				// The middle line is read before it is overwritten by the new pixel.
				below = middle_row[col_prev];
				win_left = win_center;
				win_center = win_right;
				win_right = middle_row[col];
				middle_row[col] = entering;
				above = upper_row[col];
				upper_row[col] = win_center;

				frame_done = 1'b0;
				if (in_row >= 2 || (in_row == 1 && col >= 1)) begin
					q_row = (col != 0) ? in_row - 1 : in_row - 2;
					target = erode ? TARGET_ERODE : TARGET_DILATE;
					hit = (q_row > 0 && above == target) ||
						(q_row + 1 < img_height && below == target) ||
						(col_prev > 0 && win_left == target) ||
						(col_prev + 1 < img_width && win_right == target);
					produced.pixel = hit ? target : win_center;
					produced.last = (out_pos + 1 == img_width * img_height);
					expected_pixels.push_back(produced);
					if (produced.last) begin
						restart_frame();
						frame_done = 1'b1;
					end else begin
						out_pos++;
					end
				end

				if (!frame_done) begin
					col++;
					if (col >= img_width) begin
						col = 0;
						in_row++;
					end
					in_col = col;
				end
			end

			pending_results <= expected_pixels.size();
		end
	end

endmodule

// File: tb/tb_cross_morphology_filter_top.sv
`timescale 1ns / 1ps
// Top of the cross morphology filter testbench: clock, reset, register writes and both
// stream sides with random idling; verdict from cmf_checker's mismatch and pending counts.
// Depends on cmf_pkg, cmf_checker and cross_morphology_filter_top.
module tb_cross_morphology_filter_top;
	import cmf_pkg::*;

	localparam int CLK_PERIOD_NS = 4;
	localparam int RESET_CYCLES = 2;
	localparam int RANDOM_ITEMS = 320;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_DRAIN_CYCLES = 50;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_FRAME = 2;
	localparam int HEIGHT_SAT_ITEMS = 24;
	localparam longint TIMEOUT_NS = 2_000_000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int unsigned mismatch_count;
	int unsigned pending_results;

	int cur_width;
	int cur_height;
	int item_count = 0;
	int send_steady_left = 0;
	bit hold_request = 1'b0;

	logic [7:0] corner_pixels [9] = '{8'h00, 8'hFF, 8'h80, 8'hFF, 8'h01, 8'hFE, 8'hAA, 8'h55, 8'h00};

	cross_morphology_filter_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cmf_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD_NS / 2) clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("status: fail");
		$finish;
	end

	// Output side: short random stalls, steady stretches, and one long hold on request.
	initial begin : output_side
		int unsigned pick;
		int stall_len;
		int steady_left;
		steady_left = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (steady_left > 0) begin
				steady_left--;
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 3) begin
					steady_left = $urandom_range(50, 200);
				end else if (pick < 25) begin
					stall_len = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30)
						: $urandom_range(1, 3);
					m_tready <= 1'b0;
					repeat (stall_len) @(posedge clk);
				end else begin
					m_tready <= 1'b1;
					@(posedge clk);
				end
			end
		end
	end

	function automatic int next_gap();
		int unsigned pick;
		if (send_steady_left > 0) begin
			send_steady_left--;
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 2) begin
			send_steady_left = $urandom_range(30, 150);
			return 0;
		end
		if (pick < 62) return 0;
		if (pick < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] frame_pixel();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 2) return TARGET_DILATE;
		if (pick < 4) return TARGET_ERODE;
		return 8'($urandom);
	endfunction

	task automatic send_item(input logic [7:0] pixel, input logic flush);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pixel;
		s_tuser <= flush;
		do @(posedge clk); while (!s_tready);
		item_count++;
	endtask

	// Idle until every predicted pixel has come out, then let the pipeline settle.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_geometry(input logic [CFG_DATA_W-1:0] width_raw,
		input logic [CFG_DATA_W-1:0] height_raw, input int width_eff, input int height_eff);
		write_reg(CFG_IMAGE_WIDTH, width_raw);
		write_reg(CFG_IMAGE_HEIGHT, height_raw);
		cur_width = width_eff;
		cur_height = height_eff;
	endtask

	// A negative cut_at sends the whole frame and its drain; pause_at idles mid-frame.
	task automatic send_frame(input int cut_at, input int pause_at);
		int total;
		total = cur_width * cur_height;
		for (int i = 0; i < total; i++) begin
			if (i == cut_at) return;
			if (i == pause_at) begin
				wait_idle();
				if ($urandom_range(0, 1) == 1)
					write_reg(CFG_TARGET_MODE, CFG_DATA_W'($urandom));
			end
			send_item(frame_pixel(), $urandom_range(0, 24) == 0);
		end
		for (int i = 0; i <= cur_width; i++)
			send_item(8'($urandom), $urandom_range(0, 9) < 7);
	endtask

	initial begin : stimulus
		int start_count;
		int frame_no;
		int w;
		int h;
		int total;
		int cut_at;
		int pause_at;
		logic [CFG_DATA_W-1:0] width_raw;
		bit restart_needed;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a 3x3 dilation frame with border and extreme pixels.
		set_geometry(3, 3, 3, 3);
		write_reg(CFG_TARGET_MODE, 0);
		for (int i = 0; i < 9; i++)
			send_item(corner_pixels[i], 1'b0);
		for (int i = 0; i < 4; i++)
			send_item(8'hA5, 1'b1);

		// Erosion on 2x2, with pixel transfers standing in for flush transfers.
		write_reg(CFG_TARGET_MODE, 13'h1FFF);
		set_geometry(2, 2, 2, 2);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h55, 1'b0);
		send_item(8'hAA, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h12, 1'b1);

		// Writes past the register list are ignored; width zero is one pixel wide.
		write_reg(CFG_UNUSED, 13'h1FFF);
		set_geometry(0, 3, 1, 3);
		send_item(8'hFF, 1'b0);
		send_item(8'h3C, 1'b1);
		send_item(8'h00, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(8'h7F, 1'b1);

		// Saturated width and height, each cut short once its first results
		// have come out, and then height zero.
		set_geometry(13'h1FFF, 2, MAX_WIDTH, 2);
		send_frame(MAX_WIDTH + 4, -1);
		set_geometry(1, 13'h1FFF, 1, MAX_HEIGHT);
		send_frame(HEIGHT_SAT_ITEMS, -1);
		set_geometry(5, 0, 5, 1);
		send_frame(-1, -1);

		// Random frames, some cut short, some paused, some back to back.
		start_count = item_count;
		frame_no = 0;
		restart_needed = 1'b1;
		while (item_count - start_count < RANDOM_ITEMS || frame_no <= HOLD_FRAME) begin
			if (restart_needed || frame_no == HOLD_FRAME || $urandom_range(0, 9) < 7) begin
				if (frame_no == HOLD_FRAME) begin
					w = 40;
					h = 4;
				end else begin
					case ($urandom_range(0, 19))
						0: w = $urandom_range(65, 200);
						1, 2, 3: w = $urandom_range(17, 64);
						default: w = $urandom_range(1, 16);
					endcase
					if (w > 64) h = $urandom_range(1, 3);
					else if ($urandom_range(0, 19) < 17) h = $urandom_range(1, 6);
					else h = $urandom_range(7, 20);
				end
				width_raw = CFG_DATA_W'(w);
				// Bits above the width field must be dropped by the block.
				if ($urandom_range(0, 9) == 0)
					width_raw = width_raw | CFG_DATA_W'($urandom_range(1, 3) << WIDTH_W);
				set_geometry(width_raw, CFG_DATA_W'(h), w, h);
				write_reg(CFG_TARGET_MODE, CFG_DATA_W'($urandom));
				if ($urandom_range(0, 19) == 0)
					write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
			end
			total = cur_width * cur_height;
			cut_at = ($urandom_range(0, 11) == 0) ? $urandom_range(0, total - 1) : -1;
			pause_at = ($urandom_range(0, 14) == 0 || frame_no == 1)
				? $urandom_range(0, total - 1) : -1;
			if (frame_no == HOLD_FRAME) begin
				cut_at = -1;
				hold_request = 1'b1;
			end
			send_frame(cut_at, pause_at);
			restart_needed = (cut_at >= 0);
			frame_no++;
		end

		wait_idle();
		repeat (END_DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
